// File: rtl/mbsm_pkg.sv
// Shared types and constants for the motion burst speed magnitude block.
// No dependencies; used by mbsm_mag and motion_burst_speed_magnitude_top.
package mbsm_pkg;

   // Byte position counter width and the fixed places of burst fields.
   localparam int POS_W = 4;
   localparam logic [POS_W-1:0] POS_READY   = 4'd1;
   localparam logic [POS_W-1:0] POS_X_LO    = 4'd3;
   localparam logic [POS_W-1:0] POS_X_HI    = 4'd4;
   localparam logic [POS_W-1:0] POS_Y_LO    = 4'd5;
   localparam logic [POS_W-1:0] POS_Y_HI    = 4'd6;
   localparam logic [POS_W-1:0] POS_QUALITY = 4'd7;
   localparam logic [POS_W-1:0] POS_SHUTTER = 4'd11;

   // Motion ready flag sits in bit 7 of its byte.
   localparam int READY_BIT = 7;

   // Root of a 32-bit value: one result bit per iteration.
   localparam int ROOT_ITERS = 16;
   localparam int ITER_W     = 4;

   // Largest root the block can produce (both deltas at -32768).
   localparam logic [15:0] MAG_MAX = 16'd46340;

   // Status from the magnitude engine back to the top level.
   typedef struct packed {
      logic        done;
      logic [15:0] root;
   } mag_status_type;

endpackage

// File: rtl/mbsm_mag.sv
// Magnitude engine: squares the two deltas on one shared multiplier, then
// takes an exact integer square root, one result bit per cycle. Uses mbsm_pkg.
module mbsm_mag (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [15:0]             delta_x,
   input  logic [15:0]             delta_y,
   output mbsm_pkg::mag_status_type status
);

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_SQX  = 2'd1;
   localparam logic [1:0] PH_SQY  = 2'd2;
   localparam logic [1:0] PH_ROOT = 2'd3;

   logic [1:0]                  phase_ff, phase_in;
   logic [mbsm_pkg::ITER_W-1:0] iter_ff, iter_in;
   logic                        done_ff, done_in;
   logic [31:0]                 rem_ff, rem_in;
   logic [31:0]                 root_ff, root_in;
   logic [31:0]                 bit_ff, bit_in;

   logic [15:0] abs_x;
   logic [15:0] abs_y;
   logic [15:0] operand;
   logic [31:0] product;
   logic [31:0] trial;

   // Two's complement magnitude; -32768 maps to 32768, which still fits.
   assign abs_x   = delta_x[15] ? (~delta_x + 16'd1) : delta_x;
   assign abs_y   = delta_y[15] ? (~delta_y + 16'd1) : delta_y;
   assign operand = (phase_ff == PH_SQX) ? abs_x : abs_y;
   assign product = operand * operand;
   assign trial   = root_ff + bit_ff;

   always_comb begin
      phase_in = phase_ff;
      iter_in  = iter_ff;
      done_in  = 1'b0;
      rem_in   = rem_ff;
      root_in  = root_ff;
      bit_in   = bit_ff;
      case (phase_ff)
         PH_IDLE: begin
            if (start) begin
               phase_in = PH_SQX;
            end
         end
         PH_SQX: begin
            rem_in   = product;
            phase_in = PH_SQY;
         end
         PH_SQY: begin
            // Sum of squares is at most 2^31, no carry out.
            rem_in   = rem_ff + product;
            root_in  = 32'd0;
            bit_in   = 32'd1 << 30;
            iter_in  = mbsm_pkg::ITER_W'(mbsm_pkg::ROOT_ITERS - 1);
            phase_in = PH_ROOT;
         end
         PH_ROOT: begin
            if (rem_ff >= trial) begin
               rem_in  = rem_ff - trial;
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (iter_ff == '0) begin
               done_in  = 1'b1;
               phase_in = PH_IDLE;
            end else begin
               iter_in = iter_ff - 1'b1;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      iter_ff <= iter_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
   end

   assign status.done = done_ff;
   assign status.root = root_ff[15:0];

endmodule

// File: rtl/motion_burst_speed_magnitude_top.sv
// Top level of the motion burst speed magnitude block: byte capture, request
// sequencing and the result register. Uses mbsm_pkg and mbsm_mag.
//
// Takes an optical flow sensor's motion burst one byte per request and, on the
// last byte of each burst (position BURST_BYTES-1), returns one response with
// floor(sqrt(x*x + y*y)) of the signed 16-bit X/Y deltas (bytes 3-4 and 5-6,
// low byte first), the motion ready flag (byte 1 bit 7), surface quality
// (byte 7) and shutter upper byte (byte 11). first_of_burst forces the byte
// to position 0; otherwise the position counts on and wraps after the last
// byte. Every byte but the last is taken without a stall. After the last byte,
// req_stall stays high while the magnitude engine runs: the squares on its
// shared 16x16 multiplier and then its one-bit-per-cycle square root, then
// the load of the result register; it stays high longer only if the previous
// response is still stalled. A waiting response does not block bytes of the
// next burst.
module motion_burst_speed_magnitude_top #(
   parameter int BURST_BYTES = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_burst_byte,
   input  logic        req_first_of_burst,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_speed_magnitude,
   output logic        rsp_motion_ready,
   output logic [7:0]  rsp_surface_quality,
   output logic [7:0]  rsp_shutter_hi
);

   localparam logic [mbsm_pkg::POS_W-1:0] LAST_POS = mbsm_pkg::POS_W'(BURST_BYTES - 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CALC = 2'd1;
   localparam logic [1:0] ST_HOLD = 2'd2;

   logic [1:0]                   state_ff, state_in;
   logic [mbsm_pkg::POS_W-1:0]   pos_ff, pos_in;
   logic [15:0]                  delta_x_ff, delta_x_in;
   logic [15:0]                  delta_y_ff, delta_y_in;
   logic                         ready_ff, ready_in;
   logic [7:0]                   quality_ff, quality_in;
   logic [7:0]                   shutter_ff, shutter_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [15:0]                  rsp_mag_ff;
   logic                         rsp_ready_ff;
   logic [7:0]                   rsp_quality_ff;
   logic [7:0]                   rsp_shutter_ff;

   logic                         req_accept;
   logic [mbsm_pkg::POS_W-1:0]   pos_cur;
   logic                         burst_end;
   logic                         slot_free;
   logic                         load_rsp;
   mbsm_pkg::mag_status_type     mag_status;

   // Only take bytes while the engine is idle; capture regs feed it directly.
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign pos_cur    = req_first_of_burst ? '0 : pos_ff;
   assign burst_end  = req_accept && (pos_cur == LAST_POS);

   // Response register frees up when empty or when taken this cycle.
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign load_rsp  = slot_free &&
                      (((state_ff == ST_CALC) && mag_status.done) || (state_ff == ST_HOLD));

   mbsm_mag u_mag (
      .clock   (clock),
      .reset   (reset),
      .start   (burst_end),
      .delta_x (delta_x_ff),
      .delta_y (delta_y_ff),
      .status  (mag_status)
   );

   // Capture burst fields at their byte positions; advance or wrap position.
   always_comb begin
      pos_in     = pos_ff;
      delta_x_in = delta_x_ff;
      delta_y_in = delta_y_ff;
      ready_in   = ready_ff;
      quality_in = quality_ff;
      shutter_in = shutter_ff;
      if (req_accept) begin
         pos_in = (pos_cur == LAST_POS) ? '0 : pos_cur + 1'b1;
         case (pos_cur)
            mbsm_pkg::POS_READY:   ready_in   = req_burst_byte[mbsm_pkg::READY_BIT];
            mbsm_pkg::POS_X_LO:    delta_x_in = {delta_x_ff[15:8], req_burst_byte};
            mbsm_pkg::POS_X_HI:    delta_x_in = {req_burst_byte, delta_x_ff[7:0]};
            mbsm_pkg::POS_Y_LO:    delta_y_in = {delta_y_ff[15:8], req_burst_byte};
            mbsm_pkg::POS_Y_HI:    delta_y_in = {req_burst_byte, delta_y_ff[7:0]};
            mbsm_pkg::POS_QUALITY: quality_in = req_burst_byte;
            mbsm_pkg::POS_SHUTTER: shutter_in = req_burst_byte;
            default: begin
            end
         endcase
      end
   end

   // Sequence: idle -> calc on the last byte; hold if the response is blocked.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (burst_end) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            if (mag_status.done) begin
               state_in = slot_free ? ST_IDLE : ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         delta_x_ff   <= '0;
         delta_y_ff   <= '0;
         ready_ff     <= 1'b0;
         quality_ff   <= '0;
         shutter_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         delta_x_ff   <= delta_x_in;
         delta_y_ff   <= delta_y_in;
         ready_ff     <= ready_in;
         quality_ff   <= quality_in;
         shutter_ff   <= shutter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Fields stay put while the engine runs, since requests are stalled.
   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_mag_ff     <= mag_status.root;
         rsp_ready_ff   <= ready_ff;
         rsp_quality_ff <= quality_ff;
         rsp_shutter_ff <= shutter_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_speed_magnitude = rsp_mag_ff;
   assign rsp_motion_ready    = rsp_ready_ff;
   assign rsp_surface_quality = rsp_quality_ff;
   assign rsp_shutter_hi      = rsp_shutter_ff;

   a_done_in_calc: assert property (@(posedge clock) disable iff (reset)
      mag_status.done |-> (state_ff == ST_CALC))
      else $error("engine finished outside of calc state");

   a_hold_means_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HOLD) |-> rsp_valid_ff)
      else $error("holding a result with an empty response register");

   a_pos_in_burst: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= LAST_POS)
      else $error("byte position ran past the end of the burst");

   a_mag_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_mag_ff <= mbsm_pkg::MAG_MAX))
      else $error("magnitude out of range");

   a_load_after_end: assert property (@(posedge clock) disable iff (reset)
      burst_end |=> (state_ff == ST_CALC))
      else $error("last byte did not start the engine");

endmodule
